/* hw/rtl/iute_pkg.sv */
// shared types and constants of the udp tunnel encapsulator
package iute_pkg;

  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] MIN_FRAME       = 16'd34;
  localparam logic [6:0]  ETH_BYTES       = 7'd14;
  localparam logic [6:0]  UDP_HDR_BYTES   = 7'd8;
  localparam logic [6:0]  TCP_HDR_BYTES   = 7'd20;
  localparam logic [15:0] OUTER_LEN_ADD   = 16'd28;
  localparam logic [15:0] UDP_LEN_ADD     = 16'd8;
  // 0x4550 (version, ihl, tos) plus 0x4011 (ttl, protocol)
  localparam logic [15:0] OUTER_CSUM_BASE = 16'h8561;

  typedef enum logic [1:0] {
    VERDICT_DROP    = 2'd0,
    VERDICT_PASS    = 2'd1,
    VERDICT_ENCAP   = 2'd2,
    VERDICT_WRITTEN = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    STEP_OLEN,
    STEP_ULEN,
    STEP_OC_LEN,
    STEP_OC_SRC_HI,
    STEP_OC_SRC_LO,
    STEP_OC_DST_HI,
    STEP_OC_DST_LO,
    STEP_L4_FROM_HI,
    STEP_L4_FROM_LO,
    STEP_L4_TO_HI,
    STEP_L4_TO_LO
  } step_e;

  typedef struct packed {
    logic [31:0] internal_addr;
    logic [31:0] pop_addr;
    logic [31:0] server_addr;
    logic [15:0] tunnel_port;
  } entry_t;

endpackage

/* hw/rtl/iute_ram.sv */
// generic single write port ram with registered read
module iute_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ipv4_udp_tunnel_encapsulator_top.sv */
// udp tunnel encapsulator: forwarding table, lookup and header arithmetic
// table write or early drop: goes to finish; result registered when the output register is free
// header: key scan, up to 11 sums, finish, then back to idle
// the key scan reads one table entry per cycle; one 16-bit adder, plain or end-around, does all sums
// one request at a time; the next is taken once the result is in the output register
// reset clears all valid bits and the control state; table contents stay undefined
module ipv4_udp_tunnel_encapsulator_top
  import iute_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] dest_addr_i,
  input  logic [7:0]  protocol_i,
  input  logic [15:0] inner_total_length_i,
  input  logic [3:0]  inner_header_words_i,
  input  logic [15:0] inner_l4_checksum_i,
  input  logic [15:0] frame_length_i,
  input  logic [31:0] internal_addr_i,
  input  logic [31:0] pop_addr_i,
  input  logic [31:0] server_addr_i,
  input  logic [15:0] tunnel_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [31:0] outer_src_addr_o,
  output logic [31:0] outer_dst_addr_o,
  output logic [15:0] outer_total_length_o,
  output logic [15:0] outer_header_checksum_o,
  output logic [15:0] outer_udp_length_o,
  output logic [15:0] outer_port_o,
  output logic [31:0] new_inner_dst_o,
  output logic [15:0] new_l4_checksum_o
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW = $clog2(TABLE_ENTRIES + 1);

  state_e   state_q, state_d;
  step_e    step_q, step_d;
  verdict_e verdict_q, verdict_d;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [PW-1:0] ptr_q, ptr_d;
  logic          chk_q, chk_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;

  logic [31:0] dest_q, dest_d;
  logic [15:0] tot_q, tot_d;
  logic [15:0] l4c_q, l4c_d;
  logic        l4_short_q, l4_short_d;
  logic [15:0] olen_q, olen_d;
  logic [15:0] ulen_q, ulen_d;
  logic [15:0] ochk_q, ochk_d;
  logic [15:0] l4chk_q, l4chk_d;
  logic [15:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  verdict_e    out_verdict_q;
  logic [31:0] out_src_q, out_dst_q, out_inner_q;
  logic [15:0] out_olen_q, out_ochk_q, out_ulen_q, out_port_q, out_l4_q;

  logic          accept;
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic          in_range;
  logic          key_re;
  logic          pay_re;
  logic [31:0]   key_rdata;
  entry_t        pay_wdata, pay_rdata;
  logic          key_hit;
  logic          out_load;
  logic          hdr_drop;
  logic [6:0]    l4_need;

  // shared adder, plain or with end-around carry
  logic [15:0] opa, opb;
  logic [16:0] sum;
  logic [15:0] eac;

  assign sum = {1'b0, opa} + {1'b0, opb};
  assign eac = sum[15:0] + {15'd0, sum[16]};

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = 32'(entry_index_i) < 32'(TABLE_ENTRIES);
  assign tbl_we     = accept && kind_i && in_range;
  assign tbl_waddr  = AW'({{AW{1'b0}}, entry_index_i});
  assign pay_wdata  = '{internal_addr: internal_addr_i, pop_addr: pop_addr_i,
                        server_addr: server_addr_i, tunnel_port: tunnel_port_i};

  // bytes needed up to the end of the inner l4 header
  assign l4_need = ETH_BYTES + {1'b0, inner_header_words_i, 2'b00}
                 + ((protocol_i == PROTO_UDP) ? UDP_HDR_BYTES : TCP_HDR_BYTES);
  assign hdr_drop = (frame_length_i < MIN_FRAME)
                 || ((protocol_i != PROTO_TCP) && (protocol_i != PROTO_UDP));

  assign key_hit  = chk_q && valid_q[chk_idx_q] && (key_rdata == dest_q);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  iute_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (dest_addr_i),
    .re_i    (key_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  iute_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (pay_wdata),
    .re_i    (pay_re),
    .raddr_i (chk_idx_q),
    .rdata_o (pay_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (kind_i || hdr_drop) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (key_hit) begin
          state_d = ST_CALC;
        end else if (ptr_q == PW'(TABLE_ENTRIES)) begin
          state_d = ST_FINISH;
        end
      end
      ST_CALC: begin
        if (step_q == STEP_OLEN && (sum[16] || l4_short_q)) begin
          state_d = ST_FINISH;
        end else if (step_q == STEP_L4_TO_LO) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    step_d     = step_q;
    verdict_d  = verdict_q;
    ptr_d      = ptr_q;
    chk_d      = chk_q;
    chk_idx_d  = chk_idx_q;
    dest_d     = dest_q;
    tot_d      = tot_q;
    l4c_d      = l4c_q;
    l4_short_d = l4_short_q;
    olen_d     = olen_q;
    ulen_d     = ulen_q;
    ochk_d     = ochk_q;
    l4chk_d    = l4chk_q;
    acc_d      = acc_q;
    key_re     = 1'b0;
    pay_re     = 1'b0;
    opa        = acc_q;
    opb        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          dest_d     = dest_addr_i;
          tot_d      = inner_total_length_i;
          l4c_d      = inner_l4_checksum_i;
          l4_short_d = frame_length_i < {9'd0, l4_need};
          ptr_d      = '0;
          chk_d      = 1'b0;
          if (kind_i) begin
            verdict_d = in_range ? VERDICT_WRITTEN : VERDICT_DROP;
          end else begin
            verdict_d = VERDICT_DROP;
          end
        end
      end
      ST_SCAN: begin
        if (key_hit) begin
          pay_re = 1'b1;
          step_d = STEP_OLEN;
        end else if (ptr_q == PW'(TABLE_ENTRIES)) begin
          verdict_d = VERDICT_PASS;
        end else begin
          key_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = ptr_q[AW-1:0];
          ptr_d     = ptr_q + PW'(1);
        end
      end
      ST_CALC: begin
        acc_d = eac;
        unique case (step_q)
          STEP_OLEN: begin
            opa    = tot_q;
            opb    = OUTER_LEN_ADD;
            olen_d = sum[15:0];
            step_d = STEP_ULEN;
          end
          STEP_ULEN: begin
            opa    = tot_q;
            opb    = UDP_LEN_ADD;
            ulen_d = sum[15:0];
            step_d = STEP_OC_LEN;
          end
          STEP_OC_LEN: begin
            opa    = OUTER_CSUM_BASE;
            opb    = olen_q;
            step_d = STEP_OC_SRC_HI;
          end
          STEP_OC_SRC_HI: begin
            opb    = pay_rdata.pop_addr[31:16];
            step_d = STEP_OC_SRC_LO;
          end
          STEP_OC_SRC_LO: begin
            opb    = pay_rdata.pop_addr[15:0];
            step_d = STEP_OC_DST_HI;
          end
          STEP_OC_DST_HI: begin
            opb    = pay_rdata.server_addr[31:16];
            step_d = STEP_OC_DST_LO;
          end
          STEP_OC_DST_LO: begin
            opb    = pay_rdata.server_addr[15:0];
            ochk_d = ~eac;
            step_d = STEP_L4_FROM_HI;
          end
          // rfc 1624: ~c + ~old + new
          STEP_L4_FROM_HI: begin
            opa    = ~l4c_q;
            opb    = ~dest_q[31:16];
            step_d = STEP_L4_FROM_LO;
          end
          STEP_L4_FROM_LO: begin
            opb    = ~dest_q[15:0];
            step_d = STEP_L4_TO_HI;
          end
          STEP_L4_TO_HI: begin
            opb    = pay_rdata.internal_addr[31:16];
            step_d = STEP_L4_TO_LO;
          end
          STEP_L4_TO_LO: begin
            opb       = pay_rdata.internal_addr[15:0];
            l4chk_d   = ~eac;
            verdict_d = VERDICT_ENCAP;
          end
          default: step_d = STEP_OLEN;
        endcase
        if (step_q == STEP_OLEN && (sum[16] || l4_short_q)) begin
          verdict_d = VERDICT_DROP;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_OLEN;
      valid_q     <= '0;
      ptr_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ptr_q       <= ptr_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
      if (tbl_we) begin
        valid_q[tbl_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q  <= verdict_d;
    chk_idx_q  <= chk_idx_d;
    dest_q     <= dest_d;
    tot_q      <= tot_d;
    l4c_q      <= l4c_d;
    l4_short_q <= l4_short_d;
    olen_q     <= olen_d;
    ulen_q     <= ulen_d;
    ochk_q     <= ochk_d;
    l4chk_q    <= l4chk_d;
    acc_q      <= acc_d;
  end

  // result register, fields zero unless encapsulated
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_verdict_q <= verdict_q;
      if (verdict_q == VERDICT_ENCAP) begin
        out_src_q   <= pay_rdata.pop_addr;
        out_dst_q   <= pay_rdata.server_addr;
        out_olen_q  <= olen_q;
        out_ochk_q  <= ochk_q;
        out_ulen_q  <= ulen_q;
        out_port_q  <= pay_rdata.tunnel_port;
        out_inner_q <= pay_rdata.internal_addr;
        out_l4_q    <= l4chk_q;
      end else begin
        out_src_q   <= '0;
        out_dst_q   <= '0;
        out_olen_q  <= '0;
        out_ochk_q  <= '0;
        out_ulen_q  <= '0;
        out_port_q  <= '0;
        out_inner_q <= '0;
        out_l4_q    <= '0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign verdict_o               = out_verdict_q;
  assign outer_src_addr_o        = out_src_q;
  assign outer_dst_addr_o        = out_dst_q;
  assign outer_total_length_o    = out_olen_q;
  assign outer_header_checksum_o = out_ochk_q;
  assign outer_udp_length_o      = out_ulen_q;
  assign outer_port_o            = out_port_q;
  assign new_inner_dst_o         = out_inner_q;
  assign new_l4_checksum_o       = out_l4_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_scan_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PW'(TABLE_ENTRIES))
    else $error("scan pointer ran past the table");

  a_calc_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && step_q == STEP_OLEN) |->
      (valid_q[chk_idx_q] && key_rdata == dest_q))
    else $error("header arithmetic started without a valid key match");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o != VERDICT_ENCAP) |->
      (outer_src_addr_o == '0 && outer_dst_addr_o == '0 && outer_port_o == '0
       && new_inner_dst_o == '0 && new_l4_checksum_o == '0
       && outer_header_checksum_o == '0))
    else $error("non-encapsulated result carries header fields");

endmodule

/* tb/sv/tb_ipv4_udp_tunnel_encapsulator_top.sv */
// self-checking testbench for the udp tunnel encapsulator: table writes, lookups, header sums
module tb_ipv4_udp_tunnel_encapsulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iute_pkg::*;

  localparam int TABLE_SLOTS      = 16;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int TAIL_CYCLES      = 40;
  localparam int RANDOM_PER_PHASE = 500;

  localparam logic [15:0] FRAME_FLOOR     = 16'd34;
  localparam logic [16:0] ETH_HDR         = 17'd14;
  localparam logic [16:0] UDP_HDR         = 17'd8;
  localparam logic [16:0] TCP_HDR         = 17'd20;
  localparam logic [16:0] TUNNEL_OVERHEAD = 17'd28;
  // version/ihl/tos word and ttl/protocol word of the outer header
  localparam logic [31:0] OUTER_VER_TOS   = 32'h4550;
  localparam logic [31:0] OUTER_TTL_PROTO = 32'h4011;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] dest;
    logic [7:0]  proto;
    logic [15:0] tot;
    logic [3:0]  ihl;
    logic [15:0] l4c;
    logic [15:0] flen;
    logic [31:0] internal;
    logic [31:0] pop;
    logic [31:0] server;
    logic [15:0] port;
  } request_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] olen;
    logic [15:0] ocsum;
    logic [15:0] ulen;
    logic [15:0] port;
    logic [31:0] inner_dst;
    logic [15:0] l4c;
  } result_t;

  class encap_checker;
    logic        slot_live     [TABLE_SLOTS];
    logic [31:0] slot_key      [TABLE_SLOTS];
    logic [31:0] slot_internal [TABLE_SLOTS];
    logic [31:0] slot_pop      [TABLE_SLOTS];
    logic [31:0] slot_server   [TABLE_SLOTS];
    logic [15:0] slot_port     [TABLE_SLOTS];
    result_t     awaited[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned verdict_count [4];

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      foreach (verdict_count[i]) verdict_count[i] = 0;
      mismatches = 0;
      requests   = 0;
    endfunction

    function logic [15:0] fold_ones(logic [31:0] s);
      while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
    endfunction

    function logic [15:0] ip_header_sum(logic [15:0] len, logic [31:0] src, logic [31:0] dst);
      return ~fold_ones(OUTER_VER_TOS + OUTER_TTL_PROTO + {16'd0, len}
                        + {16'd0, src[31:16]} + {16'd0, src[15:0]}
                        + {16'd0, dst[31:16]} + {16'd0, dst[15:0]});
    endfunction

    // incremental update for a changed 32-bit address word pair
    function logic [15:0] l4_adjust(logic [15:0] csum, logic [31:0] from, logic [31:0] to);
      return ~fold_ones({16'd0, ~csum} + {16'd0, ~from[31:16]} + {16'd0, ~from[15:0]}
                        + {16'd0, to[31:16]} + {16'd0, to[15:0]});
    endfunction

    function result_t predict_encap(request_t r);
      result_t     res;
      int          hit;
      logic [16:0] outer_len;
      logic [16:0] fit_need;
      res         = '0;
      res.verdict = VERDICT_DROP;
      hit         = -1;
      if (r.kind) begin
        slot_live[r.idx]     = 1'b1;
        slot_key[r.idx]      = r.dest;
        slot_internal[r.idx] = r.internal;
        slot_pop[r.idx]      = r.pop;
        slot_server[r.idx]   = r.server;
        slot_port[r.idx]     = r.port;
        res.verdict          = VERDICT_WRITTEN;
        return res;
      end
      if (r.flen < FRAME_FLOOR) return res;
      if (r.proto != PROTO_TCP && r.proto != PROTO_UDP) return res;
      // lowest live slot with the key wins
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (hit < 0 && slot_live[i] && slot_key[i] == r.dest) hit = i;
      if (hit < 0) begin
        res.verdict = VERDICT_PASS;
        return res;
      end
      outer_len = {1'b0, r.tot} + TUNNEL_OVERHEAD;
      if (outer_len[16]) return res;
      fit_need = ETH_HDR + {11'd0, r.ihl, 2'b00} + (r.proto == PROTO_UDP ? UDP_HDR : TCP_HDR);
      if ({1'b0, r.flen} < fit_need) return res;
      res.verdict   = VERDICT_ENCAP;
      res.src       = slot_pop[hit];
      res.dst       = slot_server[hit];
      res.olen      = outer_len[15:0];
      res.ocsum     = ip_header_sum(outer_len[15:0], slot_pop[hit], slot_server[hit]);
      res.ulen      = r.tot + 16'd8;
      res.port      = slot_port[hit];
      res.inner_dst = slot_internal[hit];
      res.l4c       = l4_adjust(r.l4c, r.dest, slot_internal[hit]);
      return res;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task take_request(request_t r);
      result_t res;
      res = predict_encap(r);
      awaited.push_back(res);
      verdict_count[res.verdict]++;
      requests++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task match_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      want = awaited.pop_front();
      check_field("verdict", {30'd0, got.verdict}, {30'd0, want.verdict});
      check_field("outer_src_addr", got.src, want.src);
      check_field("outer_dst_addr", got.dst, want.dst);
      check_field("outer_total_length", {16'd0, got.olen}, {16'd0, want.olen});
      check_field("outer_header_checksum", {16'd0, got.ocsum}, {16'd0, want.ocsum});
      check_field("outer_udp_length", {16'd0, got.ulen}, {16'd0, want.ulen});
      check_field("outer_port", {16'd0, got.port}, {16'd0, want.port});
      check_field("new_inner_dst", got.inner_dst, want.inner_dst);
      check_field("new_l4_checksum", {16'd0, got.l4c}, {16'd0, want.l4c});
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni               = 1'b0;
  logic        in_valid_i           = 1'b0;
  logic        in_stall_o;
  logic        kind_i               = 1'b0;
  logic [3:0]  entry_index_i        = '0;
  logic [31:0] dest_addr_i          = '0;
  logic [7:0]  protocol_i           = '0;
  logic [15:0] inner_total_length_i = '0;
  logic [3:0]  inner_header_words_i = '0;
  logic [15:0] inner_l4_checksum_i  = '0;
  logic [15:0] frame_length_i       = '0;
  logic [31:0] internal_addr_i      = '0;
  logic [31:0] pop_addr_i           = '0;
  logic [31:0] server_addr_i        = '0;
  logic [15:0] tunnel_port_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i          = 1'b0;
  logic [1:0]  verdict_o;
  logic [31:0] outer_src_addr_o;
  logic [31:0] outer_dst_addr_o;
  logic [15:0] outer_total_length_o;
  logic [15:0] outer_header_checksum_o;
  logic [15:0] outer_udp_length_o;
  logic [15:0] outer_port_o;
  logic [31:0] new_inner_dst_o;
  logic [15:0] new_l4_checksum_o;

  encap_checker encap = new();

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] known_key [TABLE_SLOTS];
  logic        known_ok  [TABLE_SLOTS];

  ipv4_udp_tunnel_encapsulator_top #(
    .TABLE_ENTRIES(TABLE_SLOTS)
  ) dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .kind_i                 (kind_i),
    .entry_index_i          (entry_index_i),
    .dest_addr_i            (dest_addr_i),
    .protocol_i             (protocol_i),
    .inner_total_length_i   (inner_total_length_i),
    .inner_header_words_i   (inner_header_words_i),
    .inner_l4_checksum_i    (inner_l4_checksum_i),
    .frame_length_i         (frame_length_i),
    .internal_addr_i        (internal_addr_i),
    .pop_addr_i             (pop_addr_i),
    .server_addr_i          (server_addr_i),
    .tunnel_port_i          (tunnel_port_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .verdict_o              (verdict_o),
    .outer_src_addr_o       (outer_src_addr_o),
    .outer_dst_addr_o       (outer_dst_addr_o),
    .outer_total_length_o   (outer_total_length_o),
    .outer_header_checksum_o(outer_header_checksum_o),
    .outer_udp_length_o     (outer_udp_length_o),
    .outer_port_o           (outer_port_o),
    .new_inner_dst_o        (new_inner_dst_o),
    .new_l4_checksum_o      (new_l4_checksum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // both handshakes sampled at the edge, plus the stuck-run watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        encap.take_request('{kind_i, entry_index_i, dest_addr_i, protocol_i,
                             inner_total_length_i, inner_header_words_i,
                             inner_l4_checksum_i, frame_length_i, internal_addr_i,
                             pop_addr_i, server_addr_i, tunnel_port_i});
      if (out_valid_o && !out_stall_i)
        encap.match_result('{verdict_e'(verdict_o), outer_src_addr_o, outer_dst_addr_o,
                             outer_total_length_o, outer_header_checksum_o,
                             outer_udp_length_o, outer_port_o, new_inner_dst_o,
                             new_l4_checksum_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic request_t table_write(logic [3:0] slot, logic [31:0] key,
                                           logic [31:0] inner, logic [31:0] src,
                                           logic [31:0] dst, logic [15:0] port);
    request_t r;
    r          = '0;
    r.kind     = 1'b1;
    r.idx      = slot;
    r.dest     = key;
    r.internal = inner;
    r.pop      = src;
    r.server   = dst;
    r.port     = port;
    return r;
  endfunction

  function automatic request_t header(logic [31:0] dest, logic [7:0] proto, logic [15:0] tot,
                                      logic [3:0] ihl, logic [15:0] csum, logic [15:0] flen);
    request_t r;
    r       = '0;
    r.dest  = dest;
    r.proto = proto;
    r.tot   = tot;
    r.ihl   = ihl;
    r.l4c   = csum;
    r.flen  = flen;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned slot;
    logic [16:0] need;
    r.kind     = ($urandom_range(99) < 15);
    r.idx      = 4'($urandom);
    r.dest     = $urandom;
    r.proto    = 8'($urandom);
    r.tot      = 16'($urandom);
    r.ihl      = 4'($urandom);
    r.l4c      = 16'($urandom);
    r.flen     = 16'($urandom);
    r.internal = $urandom;
    r.pop      = $urandom;
    r.server   = $urandom;
    r.port     = 16'($urandom);
    slot       = $urandom_range(TABLE_SLOTS - 1);
    if (r.kind) begin
      // reuse a live key now and then so duplicates appear in the table
      if ($urandom_range(99) < 30 && known_ok[slot]) r.dest = known_key[slot];
      return r;
    end
    if ($urandom_range(99) < 75 && known_ok[slot]) r.dest = known_key[slot];
    pick = $urandom_range(99);
    if (pick < 45) r.proto = PROTO_UDP;
    else if (pick < 90) r.proto = PROTO_TCP;
    pick = $urandom_range(99);
    if (pick < 70) r.tot = 16'($urandom_range(1500, 20));
    else if (pick < 80) r.tot = 16'($urandom_range(65535, 65500));
    need = ETH_HDR + {11'd0, r.ihl, 2'b00} + (r.proto == PROTO_UDP ? UDP_HDR : TCP_HDR);
    pick = $urandom_range(99);
    if (pick < 80) r.flen = 16'(need + $urandom_range(1500));
    else if (pick < 90) r.flen = 16'(need + 1 - $urandom_range(2));
    else if (pick < 95) r.flen = 16'($urandom_range(40));
    return r;
  endfunction

  task automatic send_request(input request_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    kind_i               <= r.kind;
    entry_index_i        <= r.idx;
    dest_addr_i          <= r.dest;
    protocol_i           <= r.proto;
    inner_total_length_i <= r.tot;
    inner_header_words_i <= r.ihl;
    inner_l4_checksum_i  <= r.l4c;
    frame_length_i       <= r.flen;
    internal_addr_i      <= r.internal;
    pop_addr_i           <= r.pop;
    server_addr_i        <= r.server;
    tunnel_port_i        <= r.port;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (r.kind) begin
      known_key[r.idx] = r.dest;
      known_ok[r.idx]  = 1'b1;
    end
  endtask

  // hold the sender back until every request has been answered
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (encap.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] key_a;
    key_a = 32'h0A00_0001;
    foreach (known_ok[i]) known_ok[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, short frames and foreign protocols
    send_request(header(key_a, PROTO_UDP, 16'd100, 4'd5, 16'h1111, 16'd200));
    send_request(header(key_a, PROTO_UDP, 16'd100, 4'd5, 16'h1111, 16'd33));
    send_request(header(key_a, 8'd1, 16'd100, 4'd5, 16'h1111, 16'd200));
    send_request(header(key_a, 8'hFF, 16'd100, 4'd5, 16'h1111, 16'd200));
    send_request(header(key_a, 8'd0, 16'd100, 4'd5, 16'h1111, 16'd200));
    send_request(table_write(4'd0, key_a, 32'hC0A8_0001, 32'h0102_0304, 32'h0506_0708,
                             16'h1234));
    send_request(table_write(4'd15, '1, '1, '1, '1, '1));
    send_request(table_write(4'd7, '0, '0, '0, '0, '0));
    // same key in a higher slot must lose to slot 0
    send_request(table_write(4'd9, key_a, 32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h1357_9BDF,
                             16'hABCD));
    send_request(header(key_a, PROTO_UDP, 16'd100, 4'd5, 16'h1C46, 16'd42));
    send_request(header(key_a, PROTO_UDP, 16'd100, 4'd5, 16'h1C46, 16'd41));
    send_request(header(key_a, PROTO_TCP, 16'd100, 4'd5, 16'h2222, 16'd54));
    send_request(header(key_a, PROTO_TCP, 16'd100, 4'd5, 16'h2222, 16'd53));
    send_request(header(key_a, PROTO_TCP, 16'd200, 4'd15, 16'h3333, 16'd94));
    send_request(header(key_a, PROTO_TCP, 16'd200, 4'd15, 16'h3333, 16'd93));
    send_request(header(key_a, PROTO_UDP, 16'd60, 4'd0, 16'h4444, 16'd34));
    // outer length right at and just past the 16-bit limit
    send_request(header(key_a, PROTO_UDP, 16'd65507, 4'd5, 16'h5555, 16'hFFFF));
    send_request(header(key_a, PROTO_UDP, 16'd65508, 4'd5, 16'h5555, 16'hFFFF));
    send_request(header(key_a, PROTO_TCP, 16'hFFFF, 4'd5, 16'h5555, 16'hFFFF));
    send_request(header(key_a, PROTO_UDP, 16'd0, 4'd5, 16'h0000, 16'd64));
    send_request(header(key_a, PROTO_UDP, 16'd1000, 4'd5, 16'hFFFF, 16'd1500));
    send_request(header('1, PROTO_TCP, 16'h5555, 4'd15, 16'hAAAA, 16'hFFFF));
    send_request(header('0, PROTO_UDP, 16'hAAAA, 4'd10, 16'h5555, 16'hFFFF));
    send_request(header(32'h1234_5678, PROTO_TCP, 16'd100, 4'd5, 16'h6666, 16'd100));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      repeat (RANDOM_PER_PHASE) send_request(random_request());
      drain_results();
    end
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests: %0d table writes, %0d tunnelled, %0d passed, %0d dropped",
             encap.requests, encap.verdict_count[VERDICT_WRITTEN],
             encap.verdict_count[VERDICT_ENCAP], encap.verdict_count[VERDICT_PASS],
             encap.verdict_count[VERDICT_DROP]);
    $display("pacing mixes: none, sender gaps, receiver back-pressure, both; %0d mismatches",
             encap.mismatches);
    if (encap.pending() != 0) encap.report("results still outstanding at end of run");
    if (encap.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
